FILE: hdl/fvnh_pkg.sv
// Shared types, constants and hash helpers for the fBm value-noise height block.
// No dependencies; used by every module under hdl.
package fvnh_pkg;

    typedef enum logic [2:0] {
        CFG_BASE_HEIGHT   = 3'd0,
        CFG_OCTAVE_COUNT  = 3'd1,
        CFG_OCTAVE_FREQS  = 3'd2,
        CFG_OCTAVE_AMPS   = 3'd3,
        CFG_POND_CENTER_X = 3'd4,
        CFG_POND_CENTER_Z = 3'd5,
        CFG_POND_RADIUS   = 3'd6,
        CFG_BOWL_DEPTH    = 3'd7
    } t_cfg_idx;

    typedef logic signed [20:0] t_h;

    typedef struct packed {
        logic        ok;
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    typedef struct packed {
        logic        ok;
        logic [30:0] rem;
        logic [15:0] q;
    } t_dv;

    localparam logic [31:0] LB_K1      = 32'h7feb352d;
    localparam logic [31:0] LB_K2      = 32'h846ca68b;
    localparam logic [31:0] LB_OFS_X   = 32'h9e3779b9;
    localparam logic [31:0] LB_OFS_Z   = 32'h85ebca6b;
    localparam logic [31:0] SEED0      = 32'h9e3779b9;
    localparam logic [37:0] FADE_TEN   = 38'h0A_0000_0000;
    localparam int          OCT_LAT    = 9;
    localparam int          SQRT_STEPS = 32;
    localparam int          DIV_STEPS  = 16;
    localparam int          BOWL_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 3;

    function automatic logic [31:0] lb_m1(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 16);
        return y * LB_K1;
    endfunction

    function automatic logic [31:0] lb_m2(input logic [31:0] m);
        logic [31:0] y;
        y = m ^ (m >> 15);
        return y * LB_K2;
    endfunction

    function automatic logic [31:0] lb_fin(input logic [31:0] m);
        return m ^ (m >> 16);
    endfunction

    function automatic logic [31:0] oct_seed(input int k);
        logic [31:0] s;
        s = SEED0;
        for (int i = 0; i < k; i++) begin
            s = lb_fin(lb_m2(lb_m1(s)));
        end
        return s;
    endfunction

endpackage

FILE: hdl/fbm_value_noise_height.sv
// Top level of the fBm value-noise terrain height block: config registers,
// octave cell chain, bowl path and output clamp. Depends on fvnh_pkg and the fvnh cells.
//
// One coordinate pair is taken in every cycle (o_busy stays low) and its height
// appears on o_height with o_done once it has passed the whole pipeline. The
// pipeline depth is set by the bowl path: the distance set-up registers, a chain
// of 32 square-root cells, 16 divider cells and 3 smoothstep stages; the octave
// chain runs alongside it and is delayed to match, and the output clamp register
// follows both. The receiver cannot stall: each result is shown for one cycle only.
module fbm_value_noise_height import fvnh_pkg::*; #(
    parameter int MAX_OCTAVES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata,
    output logic               o_done,
    output logic [16:0]        o_height
);

    localparam int CHAIN_LAT = OCT_LAT * MAX_OCTAVES;
    localparam int ALIGN     = BOWL_LAT - CHAIN_LAT;
    localparam int TOTAL_LAT = BOWL_LAT + 1;

    logic [16:0]        r_base;
    logic [2:0]         r_count;
    logic [63:0]        r_freqs;
    logic [63:0]        r_amps;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cz;
    logic [30:0]        r_rad;
    logic [16:0]        r_depth;
    logic [61:0]        r_r2;

    logic [TOTAL_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
            r_freqs <= '0;
            r_amps  <= '0;
            r_cx    <= '0;
            r_cz    <= '0;
            r_rad   <= '0;
            r_depth <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_HEIGHT:   r_base  <= i_cfg_wdata[16:0];
                CFG_OCTAVE_COUNT:  r_count <= i_cfg_wdata[2:0];
                CFG_OCTAVE_FREQS:  r_freqs <= i_cfg_wdata;
                CFG_OCTAVE_AMPS:   r_amps  <= i_cfg_wdata;
                CFG_POND_CENTER_X: r_cx    <= i_cfg_wdata[31:0];
                CFG_POND_CENTER_Z: r_cz    <= i_cfg_wdata[31:0];
                CFG_POND_RADIUS:   r_rad   <= i_cfg_wdata[30:0];
                CFG_BOWL_DEPTH:    r_depth <= i_cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= 62'(r_rad) * 62'(r_rad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_start};
        end
    end

    assign o_busy = 1'b0;

    // octave chain
    logic [2:0] n_eff;
    assign n_eff = (r_count > 3'(MAX_OCTAVES)) ? 3'(MAX_OCTAVES) : r_count;

    logic signed [31:0] cx [MAX_OCTAVES];
    logic signed [31:0] cz [MAX_OCTAVES];
    t_h                 ch [MAX_OCTAVES+1];

    assign cx[0] = i_coord_x;
    assign cz[0] = i_coord_z;
    assign ch[0] = $signed({4'b0, r_base});

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        localparam logic [31:0] SEED = oct_seed(k);
        if (k < MAX_OCTAVES - 1) begin : g_mid
            fvnh_oct_cell u_cell (
                .i_clk  (i_clk),
                .i_seed (SEED),
                .i_en   (3'(k) < n_eff),
                .i_freq (r_freqs[16*k +: 16]),
                .i_amp  (r_amps[16*k +: 16]),
                .i_x    (cx[k]),
                .i_z    (cz[k]),
                .i_h    (ch[k]),
                .o_x    (cx[k+1]),
                .o_z    (cz[k+1]),
                .o_h    (ch[k+1])
            );
        end else begin : g_last
            fvnh_oct_cell u_cell (
                .i_clk  (i_clk),
                .i_seed (SEED),
                .i_en   (3'(k) < n_eff),
                .i_freq (r_freqs[16*k +: 16]),
                .i_amp  (r_amps[16*k +: 16]),
                .i_x    (cx[k]),
                .i_z    (cz[k]),
                .i_h    (ch[k]),
                .o_x    (),
                .o_z    (),
                .o_h    (ch[k+1])
            );
        end
    end

    t_h r_hal [ALIGN];

    always_ff @(posedge i_clk) begin
        r_hal[0] <= ch[MAX_OCTAVES];
        for (int i = 1; i < ALIGN; i++) begin
            r_hal[i] <= r_hal[i-1];
        end
    end

    // bowl front end
    logic signed [32:0] r_dx, r_dz;
    logic [30:0]        r_adx, r_adz;
    logic               r_inr2, r_inr3;
    logic [61:0]        r_sx, r_sz;
    t_sq                r_b4;
    logic [32:0]        adx, adz;
    logic [62:0]        d2;

    always_comb begin
        adx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        adz = r_dz[32] ? 33'(-r_dz) : 33'(r_dz);
        d2  = 63'(r_sx) + 63'(r_sz);
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= 33'(i_coord_x) - 33'(r_cx);
        r_dz    <= 33'(i_coord_z) - 33'(r_cz);
        r_adx   <= adx[30:0];
        r_adz   <= adz[30:0];
        r_inr2  <= (adx < {2'b0, r_rad}) && (adz < {2'b0, r_rad}) && (r_rad != '0);
        r_sx    <= 62'(r_adx) * 62'(r_adx);
        r_sz    <= 62'(r_adz) * 62'(r_adz);
        r_inr3  <= r_inr2;
        r_b4.ok  <= r_inr3 && (d2 < 63'(r_r2));
        r_b4.v   <= 64'(d2);
        r_b4.res <= '0;
    end

    t_sq sq [SQRT_STEPS+1];
    assign sq[0] = r_b4;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        fvnh_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_bit (64'd1 << (62 - 2*k)),
            .i_sq  (sq[k]),
            .o_sq  (sq[k+1])
        );
    end

    t_dv dv [DIV_STEPS+1];
    assign dv[0].ok  = sq[SQRT_STEPS].ok;
    assign dv[0].rem = sq[SQRT_STEPS].res[30:0];
    assign dv[0].q   = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        fvnh_div_cell u_cell (
            .i_clk (i_clk),
            .i_r   (r_rad),
            .i_dv  (dv[k]),
            .o_dv  (dv[k+1])
        );
    end

    // smoothstep falloff and depth
    logic [15:0] r_st, r_st2;
    logic        r_sok, r_fok;
    logic [16:0] r_fall;
    logic [17:0] r_amt;
    logic [31:0] tt;
    logic [33:0] sp;
    logic [17:0] s;
    logic [33:0] ap;

    always_comb begin
        tt = 32'(dv[DIV_STEPS].q) * 32'(dv[DIV_STEPS].q);
        sp = 34'(r_st2) * 34'(18'd196608 - {1'b0, r_st, 1'b0});
        s  = sp[33:16];
        ap = 34'(r_depth) * 34'(r_fall);
    end

    always_ff @(posedge i_clk) begin
        r_st   <= dv[DIV_STEPS].q;
        r_st2  <= tt[31:16];
        r_sok  <= dv[DIV_STEPS].ok;
        r_fall <= (s >= 18'd65536) ? 17'd0 : 17'(18'd65536 - s);
        r_fok  <= r_sok;
        r_amt  <= r_fok ? ap[33:16] : 18'd0;
    end

    // merge and clamp
    t_h          fin;
    logic [16:0] r_height;

    assign fin = r_hal[ALIGN-1] - $signed({3'b0, r_amt});

    always_ff @(posedge i_clk) begin
        if (fin < 0) begin
            r_height <= 17'd0;
        end else if (fin > 21'sd65536) begin
            r_height <= 17'd65536;
        end else begin
            r_height <= fin[16:0];
        end
    end

    assign o_done   = r_vld[TOTAL_LAT-1];
    assign o_height = r_height;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##TOTAL_LAT o_done)
        else $error("accepted sample gave no result");

    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, TOTAL_LAT))
        else $error("result without a transfer");

    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_height <= 17'd65536))
        else $error("height out of range");

endmodule

FILE: hdl/fvnh_oct_cell.sv
// One octave cell: value noise for one lattice frequency, added to the running height.
// Nine register stages; depends on fvnh_pkg.
module fvnh_oct_cell import fvnh_pkg::*; (
    input  logic               i_clk,
    input  logic [31:0]        i_seed,
    input  logic               i_en,
    input  logic [15:0]        i_freq,
    input  logic [15:0]        i_amp,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_z,
    input  t_h                 i_h,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_z,
    output t_h                 o_h
);

    logic signed [31:0] r_xd [OCT_LAT];
    logic signed [31:0] r_zd [OCT_LAT];
    t_h                 r_hd [OCT_LAT-1];

    logic signed [48:0] r_px, r_pz;
    logic [31:0] r_m1 [4];
    logic [31:0] r_m2 [4];
    logic [31:0] r_c1 [4];
    logic [31:0] r_c2 [4];
    logic [15:0] r_ft [2];
    logic [31:0] r_ft2 [2];
    logic [47:0] r_ft3 [2];
    logic [37:0] r_fq [2];
    logic [16:0] r_u [2];
    logic [16:0] r_u5 [2];
    logic [16:0] r_uz6;
    logic [23:0] r_v0a, r_v0b;
    logic        r_ga, r_gb;
    logic [39:0] r_lpa, r_lpb;
    logic [23:0] r_a7;
    logic        r_gz;
    logic [39:0] r_lz;
    logic        r_pos;
    logic [40:0] r_cp;
    t_h          r_hout;

    logic [31:0] ix, iz;
    logic [15:0] tx, tz;
    logic [31:0] hx0, hx1, hz0, hz1;
    logic [37:0] fp [2];
    logic [21:0] fsh [2];
    logic [31:0] cv [4];
    logic [23:0] v [4];
    logic [23:0] da, db, a, b, dz, nv;
    logic [24:0] c2, mag;
    logic        c_pos;
    t_h          delta;

    always_comb begin
        ix = {{7{r_px[48]}}, r_px[48:24]};
        iz = {{7{r_pz[48]}}, r_pz[48:24]};
        tx = r_px[23:8];
        tz = r_pz[23:8];
        hx0 = lb_fin(r_m2[0]);
        hx1 = lb_fin(r_m2[1]);
        hz0 = lb_fin(r_m2[2]);
        hz1 = lb_fin(r_m2[3]);
        for (int j = 0; j < 2; j++) begin
            fp[j]  = 38'(r_ft3[j][47:32]) * 38'(r_fq[j][37:16]);
            fsh[j] = fp[j][37:16];
        end
        for (int i = 0; i < 4; i++) begin
            cv[i] = lb_fin(r_c2[i]);
            v[i]  = cv[i][31:8];
        end
        da = (v[1] >= v[0]) ? v[1] - v[0] : v[0] - v[1];
        db = (v[3] >= v[2]) ? v[3] - v[2] : v[2] - v[3];
        a  = r_ga ? r_v0a + r_lpa[39:16] : r_v0a - r_lpa[39:16];
        b  = r_gb ? r_v0b + r_lpb[39:16] : r_v0b - r_lpb[39:16];
        dz = (b >= a) ? b - a : a - b;
        nv = r_gz ? r_a7 + r_lz[39:16] : r_a7 - r_lz[39:16];
        c2 = {nv, 1'b0};
        c_pos = c2[24];
        mag = c_pos ? c2 - 25'h1000000 : 25'h1000000 - c2;
        delta = $signed({4'b0, r_cp[40:24]});
    end

    always_ff @(posedge i_clk) begin
        r_xd[0] <= i_x;
        r_zd[0] <= i_z;
        r_hd[0] <= i_h;
        for (int i = 1; i < OCT_LAT; i++) begin
            r_xd[i] <= r_xd[i-1];
            r_zd[i] <= r_zd[i-1];
        end
        for (int i = 1; i < OCT_LAT - 1; i++) begin
            r_hd[i] <= r_hd[i-1];
        end

        r_px <= $signed(i_x) * $signed({1'b0, i_freq});
        r_pz <= $signed(i_z) * $signed({1'b0, i_freq});

        r_m1[0] <= lb_m1(ix + LB_OFS_X);
        r_m1[1] <= lb_m1(ix + 32'd1 + LB_OFS_X);
        r_m1[2] <= lb_m1(iz + LB_OFS_Z);
        r_m1[3] <= lb_m1(iz + 32'd1 + LB_OFS_Z);
        r_ft[0]  <= tx;
        r_ft[1]  <= tz;
        r_ft2[0] <= 32'(tx) * 32'(tx);
        r_ft2[1] <= 32'(tz) * 32'(tz);

        for (int i = 0; i < 4; i++) begin
            r_m2[i] <= lb_m2(r_m1[i]);
            r_c2[i] <= lb_m2(r_c1[i]);
        end
        for (int j = 0; j < 2; j++) begin
            r_ft3[j] <= 48'(r_ft2[j]) * 48'(r_ft[j]);
            r_fq[j]  <= 38'd6 * 38'(r_ft2[j]) + FADE_TEN
                        - 38'd15 * {6'b0, r_ft[j], 16'b0};
            r_u[j]   <= (fsh[j] > 22'd65536) ? 17'd65536 : fsh[j][16:0];
            r_u5[j]  <= r_u[j];
        end

        r_c1[0] <= lb_m1(i_seed ^ hx0 ^ hz0);
        r_c1[1] <= lb_m1(i_seed ^ hx1 ^ hz0);
        r_c1[2] <= lb_m1(i_seed ^ hx0 ^ hz1);
        r_c1[3] <= lb_m1(i_seed ^ hx1 ^ hz1);

        r_v0a <= v[0];
        r_v0b <= v[2];
        r_ga  <= v[1] >= v[0];
        r_gb  <= v[3] >= v[2];
        r_lpa <= 40'(da) * 40'(r_u5[0]);
        r_lpb <= 40'(db) * 40'(r_u5[0]);
        r_uz6 <= r_u5[1];

        r_a7 <= a;
        r_gz <= b >= a;
        r_lz <= 40'(dz) * 40'(r_uz6);

        r_pos <= c_pos;
        r_cp  <= 41'(i_amp) * 41'(mag);

        if (!i_en) begin
            r_hout <= r_hd[OCT_LAT-2];
        end else if (r_pos) begin
            r_hout <= r_hd[OCT_LAT-2] + delta;
        end else begin
            r_hout <= r_hd[OCT_LAT-2] - delta;
        end
    end

    assign o_x = r_xd[OCT_LAT-1];
    assign o_z = r_zd[OCT_LAT-1];
    assign o_h = r_hout;

endmodule

FILE: hdl/fvnh_sqrt_cell.sv
// One step of the digit-by-digit integer square root, registered.
// Depends on fvnh_pkg for the stage record.
module fvnh_sqrt_cell import fvnh_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_bit,
    input  t_sq         i_sq,
    output t_sq         o_sq
);

    t_sq         r_sq;
    logic [63:0] sum;
    t_sq         n_sq;

    always_comb begin
        sum     = i_sq.res + i_bit;
        n_sq.ok = i_sq.ok;
        if (i_sq.v >= sum) begin
            n_sq.v   = i_sq.v - sum;
            n_sq.res = (i_sq.res >> 1) + i_bit;
        end else begin
            n_sq.v   = i_sq.v;
            n_sq.res = i_sq.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= n_sq;
    end

    assign o_sq = r_sq;

endmodule

FILE: hdl/fvnh_div_cell.sv
// One quotient bit of the restoring divide of distance by pond radius, registered.
// Depends on fvnh_pkg for the stage record.
module fvnh_div_cell import fvnh_pkg::*; (
    input  logic        i_clk,
    input  logic [30:0] i_r,
    input  t_dv         i_dv,
    output t_dv         o_dv
);

    t_dv         r_dv;
    logic [31:0] rem2;
    logic        ge;
    t_dv         n_dv;

    always_comb begin
        rem2      = {i_dv.rem, 1'b0};
        ge        = rem2 >= {1'b0, i_r};
        n_dv.ok   = i_dv.ok;
        n_dv.rem  = ge ? 31'(rem2 - {1'b0, i_r}) : rem2[30:0];
        n_dv.q    = {i_dv.q[14:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_dv <= n_dv;
    end

    assign o_dv = r_dv;

endmodule

FILE: tb/fbm_value_noise_height_checker.sv
// Checker for the fBm value-noise height block: watches the config port and the
// sample/result transfers, predicts each height and compares. Depends on fvnh_pkg.
`timescale 1ns / 1ps
module fbm_value_noise_height_checker import fvnh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata,
    input  logic               i_done,
    input  logic [16:0]        i_height,
    output int                 o_fail_count,
    output int                 o_pending
);
    logic [16:0] base_height;
    logic [2:0]  octave_count;
    logic [63:0] octave_freqs;
    logic [63:0] octave_amps;
    logic [31:0] pond_cx;
    logic [31:0] pond_cz;
    logic [30:0] pond_radius;
    logic [16:0] bowl_depth;
    logic [16:0] heights_due[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = heights_due.size();

    function automatic logic [31:0] mix32(input logic [31:0] v);
        logic [31:0] x;
        x = v;
        x = x ^ (x >> 16);
        x = x * 32'h7feb352d;
        x = x ^ (x >> 15);
        x = x * 32'h846ca68b;
        x = x ^ (x >> 16);
        return x;
    endfunction

    function automatic longint unsigned lattice_val(input logic [31:0] seed,
                                                    input logic [31:0] cx,
                                                    input logic [31:0] cz);
        logic [31:0] h;
        h = mix32(seed ^ mix32(cx + 32'h9e3779b9) ^ mix32(cz + 32'h85ebca6b));
        return longint'(h >> 8);
    endfunction

    function automatic longint unsigned quintic(input longint unsigned t);
        longint unsigned t3, q, f;
        t3 = (t * t * t) >> 32;
        q  = 6 * t * t + 10 * (64'd1 << 32) - 15 * t * 65536;
        f  = (t3 * (q >> 16)) >> 16;
        return (f > 65536) ? 65536 : f;
    endfunction

    function automatic longint unsigned blend(input longint unsigned v0,
                                              input longint unsigned v1,
                                              input longint unsigned u);
        if (v1 >= v0) return v0 + (((v1 - v0) * u) >> 16);
        return v0 - (((v0 - v1) * u) >> 16);
    endfunction

    function automatic longint unsigned root(input longint unsigned v);
        longint unsigned r, b, x;
        x = v;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned noise2d(input longint x, input longint z,
                                                input longint unsigned f,
                                                input logic [31:0] seed);
        longint unsigned px, pz, tx, tz, ux, uz, a, b;
        logic [31:0] ix, iz;
        px = longint'(x * longint'(f)) + (64'd1 << 48);
        pz = longint'(z * longint'(f)) + (64'd1 << 48);
        ix = 32'((px >> 24) - (64'd1 << 24));
        iz = 32'((pz >> 24) - (64'd1 << 24));
        tx = (px >> 8) & 64'hFFFF;
        tz = (pz >> 8) & 64'hFFFF;
        ux = quintic(tx);
        uz = quintic(tz);
        a = blend(lattice_val(seed, ix, iz), lattice_val(seed, ix + 1, iz), ux);
        b = blend(lattice_val(seed, ix, iz + 1), lattice_val(seed, ix + 1, iz + 1), ux);
        return blend(a, b, uz);
    endfunction

    function automatic logic [16:0] terrain_height(input logic [31:0] cx,
                                                   input logic [31:0] cz);
        longint x, z, h, dx, dz;
        longint unsigned f, amp, nv, c2, adx, adz, r, d2, t, t2, s, fall;
        logic [31:0] seed;
        int n;
        x = longint'(signed'(cx));
        z = longint'(signed'(cz));
        h = longint'(base_height);
        seed = 32'h9e3779b9;
        n = (octave_count > 4) ? 4 : int'(octave_count);
        for (int k = 0; k < n; k++) begin
            f   = (octave_freqs >> (16 * k)) & 64'hFFFF;
            amp = (octave_amps >> (16 * k)) & 64'hFFFF;
            nv  = noise2d(x, z, f, seed);
            c2  = 2 * nv;
            if (c2 >= (64'd1 << 24)) h += longint'((amp * (c2 - (64'd1 << 24))) >> 24);
            else h -= longint'((amp * ((64'd1 << 24) - c2)) >> 24);
            seed = mix32(seed);
        end
        if (pond_radius != 0) begin
            dx  = x - longint'(signed'(pond_cx));
            dz  = z - longint'(signed'(pond_cz));
            adx = (dx < 0) ? -dx : dx;
            adz = (dz < 0) ? -dz : dz;
            r   = longint'(pond_radius);
            if (adx < r && adz < r) begin
                d2 = adx * adx + adz * adz;
                if (d2 < r * r) begin
                    t    = (root(d2) << 16) / r;
                    t2   = (t * t) >> 16;
                    s    = (t2 * (3 * 65536 - 2 * t)) >> 16;
                    fall = (s >= 65536) ? 0 : 65536 - s;
                    h   -= longint'((longint'(bowl_depth) * fall) >> 16);
                end
            end
        end
        if (h < 0) h = 0;
        if (h > 65536) h = 65536;
        return 17'(h);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_height  <= '0;
            octave_count <= '0;
            octave_freqs <= '0;
            octave_amps  <= '0;
            pond_cx      <= '0;
            pond_cz      <= '0;
            pond_radius  <= '0;
            bowl_depth   <= '0;
            fails        <= 0;
            heights_due.delete();
        end else begin
            if (i_done) begin
                if (heights_due.size() == 0) begin
                    if (fails < 10) $display("unexpected height %0d", i_height);
                    fails <= fails + 1;
                end else if (heights_due[0] !== i_height) begin
                    if (fails < 10)
                        $display("height mismatch: expected %0d actual %0d",
                                 heights_due[0], i_height);
                    fails <= fails + 1;
                    void'(heights_due.pop_front());
                end else begin
                    void'(heights_due.pop_front());
                end
            end
            if (i_start && !i_busy)
                heights_due = {heights_due, terrain_height(i_coord_x, i_coord_z)};
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_HEIGHT:   base_height  <= i_cfg_wdata[16:0];
                    CFG_OCTAVE_COUNT:  octave_count <= i_cfg_wdata[2:0];
                    CFG_OCTAVE_FREQS:  octave_freqs <= i_cfg_wdata;
                    CFG_OCTAVE_AMPS:   octave_amps  <= i_cfg_wdata;
                    CFG_POND_CENTER_X: pond_cx      <= i_cfg_wdata[31:0];
                    CFG_POND_CENTER_Z: pond_cz      <= i_cfg_wdata[31:0];
                    CFG_POND_RADIUS:   pond_radius  <= i_cfg_wdata[30:0];
                    CFG_BOWL_DEPTH:    bowl_depth   <= i_cfg_wdata[16:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: tb/fbm_value_noise_height_test.sv
// Testbench top for fbm_value_noise_height: drives config phases and samples,
// gives the verdict. Depends on fvnh_pkg and fbm_value_noise_height_checker.
`timescale 1ns / 1ps
module fbm_value_noise_height_test;
    import fvnh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_z = '0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [63:0]        i_cfg_wdata = '0;
    logic               o_done;
    logic [16:0]        o_height;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;
    logic               idle_allowed = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fbm_value_noise_height uut (.*);

    fbm_value_noise_height_checker height_check (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_coord_x, .i_coord_z,
        .i_cfg_we, .i_cfg_idx, .i_cfg_wdata, .i_done(o_done), .i_height(o_height),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // hold start high across back-to-back transfers; drop it only for idle bursts
    task automatic send_sample(input logic [31:0] x, input logic [31:0] z);
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_coord_x <= x;
        i_coord_z <= z;
        do @(posedge i_clk); while (o_busy);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
        endcase
    endfunction

    task automatic random_config(input int mode);
        write_reg(CFG_BASE_HEIGHT, mode == 0 ? 64'd65536 : 64'($urandom_range(0, 131071)));
        write_reg(CFG_OCTAVE_COUNT, mode == 0 ? 64'd7 : 64'($urandom_range(0, 7)));
        write_reg(CFG_OCTAVE_FREQS, mode == 0 ? '1 : {$urandom(), $urandom()});
        write_reg(CFG_OCTAVE_AMPS, mode == 0 ? '1 : {$urandom(), $urandom()});
        write_reg(CFG_POND_CENTER_X, mode == 0 ? 64'h8000_0000 : 64'(rand_coord()));
        write_reg(CFG_POND_CENTER_Z, mode == 0 ? 64'h7FFF_FFFF : 64'(rand_coord()));
        write_reg(CFG_POND_RADIUS, mode == 0 ? 64'h7FFF_FFFF
                  : ($urandom_range(0, 1) ? 64'($urandom_range(1, 30 << 16))
                                          : 64'($urandom() >> 1)));
        write_reg(CFG_BOWL_DEPTH, mode == 0 ? 64'd131071 : 64'($urandom_range(0, 131071)));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: defaults, then small pond with zero frequency octave
        send_sample(32'h0, 32'h0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        drain();
        write_reg(CFG_BASE_HEIGHT, 64'd32768);
        write_reg(CFG_OCTAVE_COUNT, 64'd4);
        write_reg(CFG_OCTAVE_FREQS, 64'h0100_0080_0000_FFFF);
        write_reg(CFG_OCTAVE_AMPS, 64'hFFFF_4000_8000_FFFF);
        write_reg(CFG_POND_CENTER_X, 64'h0000_0000);
        write_reg(CFG_POND_CENTER_Z, 64'h0000_0000);
        write_reg(CFG_POND_RADIUS, 64'h0004_0000);
        write_reg(CFG_BOWL_DEPTH, 64'd65536);
        send_sample(32'h0, 32'h0);
        send_sample(32'h0003_FFFF, 32'h0);
        send_sample(32'h0004_0000, 32'h0);
        send_sample(32'h0002_0000, 32'hFFFE_0000);
        send_sample(32'h0003_0000, 32'h0003_0000);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h0000_8000, 32'hFFFF_8000);
        drain();
        random_config(0);
        for (int i = 0; i < 8; i++) send_sample(rand_coord(), rand_coord());
        drain();
        for (int phase = 0; phase < 13; phase++) begin
            if (phase == 12) idle_allowed = 1'b0;
            random_config(1);
            for (int i = 0; i < 50; i++) send_sample(rand_coord(), rand_coord());
            drain();
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
